### rtl/dmrc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and handshake structs of the desk motor ramp controller.
package dmrc_pkg;

  // Height averaging window and derived widths
  localparam int AVG_WINDOW  = 10;
  localparam int Q_W         = 16;
  localparam int ECHO_W      = 20;
  localparam int CNT_W       = $clog2(AVG_WINDOW + 1);
  localparam int PTR_W       = (AVG_WINDOW > 1) ? $clog2(AVG_WINDOW) : 1;
  localparam int SUM_W       = Q_W + CNT_W;
  localparam int DIV_STEPS   = (SUM_W + 1) / 2;
  localparam int DIV_W       = 2 * DIV_STEPS;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  // Echo to 1/256 cm: q = floor(echo * 544 / 125), done as a reciprocal multiply.
  // A valid echo is below 15000 us, so 14 echo bits and a 24-bit product stay exact.
  localparam int VALID_ECHO_W = 14;
  localparam int X_W          = 24;
  localparam int PROD_W       = 2 * X_W;
  localparam int Q_NUM        = 544;
  localparam int Q_RECIP      = 8589935;
  localparam int Q_SHIFT      = 30;
  localparam int ECHO_K       = 17;
  localparam int VALID_SCALE  = 1000;
  localparam int LIM_W        = ECHO_W + 5;

  // Operating modes
  localparam logic [2:0] MODE_UP    = 3'd0;
  localparam logic [2:0] MODE_DOWN  = 3'd1;
  localparam logic [2:0] MODE_AUP   = 3'd2;
  localparam logic [2:0] MODE_ADOWN = 3'd3;
  localparam logic [2:0] MODE_OFF   = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_LIM    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BOT_LIM    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_VALID_LIM  = 3'd7;

  // Measurement request to the averaging unit
  typedef struct packed {
    logic              start;
    logic [ECHO_W-1:0] echo;
    logic [7:0]        valid_limit;
  } meas_req_t;

  // Averaging unit status
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
    logic [Q_W-1:0]   avg;
  } meas_rsp_t;

endpackage

### rtl/dmrc_avg.sv
`timescale 1ns / 1ps
// Height averaging unit: sample ring memory, running sum and radix-4 divider.
module dmrc_avg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dmrc_pkg::meas_req_t req_i,
  output dmrc_pkg::meas_rsp_t rsp_o
);
  import dmrc_pkg::*;

  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_MUL  = 2'd1;
  localparam logic [1:0] A_UPD  = 2'd2;
  localparam logic [1:0] A_DIV  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [Q_W-1:0]    avg_q, avg_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              vld_q, vld_d;

  logic [X_W-1:0]    x_q;
  logic [PROD_W-1:0] prod_q;
  logic [Q_W-1:0]    rd_q;
  logic [DIV_W-1:0]  dq_q, dq_d;
  logic [CNT_W:0]    rem_q, rem_d;

  logic [Q_W-1:0]    ring_mem [AVG_WINDOW];
  logic              ring_re, ring_we;
  logic [Q_W-1:0]    q_val;
  logic              done;

  logic [LIM_W-1:0]  echo_k, lim_k;
  logic [DIV_W-1:0]  dstep;
  logic [CNT_W:0]    rstep;

  assign echo_k  = LIM_W'(req_i.echo) * LIM_W'(ECHO_K);
  assign lim_k   = LIM_W'(req_i.valid_limit) * LIM_W'(VALID_SCALE);
  assign ring_re = (state_q == A_IDLE) && req_i.start;
  assign q_val   = prod_q[Q_SHIFT +: Q_W];

  // Two restoring division steps per cycle
  always_comb begin
    logic [CNT_W:0]   r;
    logic [DIV_W-1:0] d;
    r = rem_q;
    d = dq_q;
    for (int i = 0; i < 2; i++) begin
      r = {r[CNT_W-1:0], d[DIV_W-1]};
      d = {d[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, cnt_q}) begin
        r = r - {1'b0, cnt_q};
        d[0] = 1'b1;
      end
    end
    rstep = r;
    dstep = d;
  end

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    avg_d   = avg_q;
    step_d  = step_q;
    vld_d   = vld_q;
    dq_d    = dq_q;
    rem_d   = rem_q;
    ring_we = 1'b0;
    done    = 1'b0;
    case (state_q)
      A_IDLE: begin
        if (req_i.start) begin
          vld_d   = echo_k < lim_k;
          state_d = A_MUL;
        end
      end
      A_MUL: begin
        state_d = A_UPD;
      end
      A_UPD: begin
        if (vld_q) begin
          ring_we = 1'b1;
          if (cnt_q == CNT_W'(AVG_WINDOW)) begin
            sum_d = sum_q - SUM_W'(rd_q) + SUM_W'(q_val);
          end else begin
            cnt_d = cnt_q + 1'b1;
            sum_d = sum_q + SUM_W'(q_val);
          end
          ptr_d   = (ptr_q == PTR_W'(AVG_WINDOW - 1)) ? '0 : ptr_q + 1'b1;
          dq_d    = DIV_W'(sum_d);
          rem_d   = '0;
          step_d  = '0;
          state_d = A_DIV;
        end else begin
          done    = 1'b1;
          state_d = A_IDLE;
        end
      end
      A_DIV: begin
        dq_d   = dstep;
        rem_d  = rstep;
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          avg_d   = dstep[Q_W-1:0];
          done    = 1'b1;
          state_d = A_IDLE;
        end
      end
      default: begin
        state_d = A_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      ptr_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      avg_q   <= '0;
      step_q  <= '0;
      vld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      avg_q   <= avg_d;
      step_q  <= step_d;
      vld_q   <= vld_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (ring_re) begin
      x_q <= X_W'(req_i.echo[VALID_ECHO_W-1:0]) * X_W'(Q_NUM);
    end
    if (state_q == A_MUL) begin
      prod_q <= PROD_W'(x_q) * PROD_W'(Q_RECIP);
    end
    dq_q  <= dq_d;
    rem_q <= rem_d;
  end

  // Ring memory: the oldest entry is read on start, the new sample written back in update
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ptr_q] <= q_val;
    end
    if (ring_re) begin
      rd_q <= ring_mem[ptr_q];
    end
  end

  assign rsp_o.busy  = state_q != A_IDLE;
  assign rsp_o.done  = done;
  assign rsp_o.sum   = sum_q;
  assign rsp_o.count = cnt_q;
  assign rsp_o.avg   = avg_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(AVG_WINDOW))
    else $error("sample count exceeds window");

  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_W'(AVG_WINDOW - 1))
    else $error("ring pointer out of range");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (state_q == A_IDLE) && !rsp_o.done)
    else $error("averaging unit not idle after done");

endmodule

### rtl/desk_motor_ramp_controller_unit.sv
`timescale 1ns / 1ps
// Top level of the desk motor ramp controller: button modes, limits, ramp and output register.
//
//  channel  direction  handshake                   payload
//  in       input      in_valid_i / in_stall_o     now_ms, button events, echo_us
//  out      output     out_valid_o / out_stall_i   motor_enable, pwm_up/down, mode, height_q8
//  cfg      input      cfg_we_i                    cfg_idx_i, cfg_data_i
//
// A pass without a measurement runs the event, report, ramp and output steps back to idle.
// Each measurement adds the start, wait and post steps, and the averaging unit runs its
// radix-4 divider only when the reading is accepted.
// Reset is asynchronous and active low; the sample ring needs no clearing pass.
// The next pass is accepted while a result still waits in the output register; a pass
// holds in its last step only while that register is full and stalled.
module desk_motor_ramp_controller_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [dmrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dmrc_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [31:0]                    now_ms_i,
  input  logic                           up_double_i,
  input  logic                           down_double_i,
  input  logic                           up_long_i,
  input  logic                           down_long_i,
  input  logic                           up_released_i,
  input  logic                           down_released_i,
  input  logic [dmrc_pkg::ECHO_W-1:0]    echo_us_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           motor_enable_o,
  output logic [7:0]                     pwm_up_o,
  output logic [7:0]                     pwm_down_o,
  output logic [2:0]                     mode_o,
  output logic [dmrc_pkg::Q_W-1:0]       height_q8_o
);
  import dmrc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVENT  = 3'd1;
  localparam logic [2:0] S_MSTART = 3'd2;
  localparam logic [2:0] S_MWAIT  = 3'd3;
  localparam logic [2:0] S_MPOST  = 3'd4;
  localparam logic [2:0] S_REPORT = 3'd5;
  localparam logic [2:0] S_RAMP   = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  // Configuration
  logic [7:0]  min_speed_q, max_speed_q, speed_step_q, top_lim_q, bot_lim_q, valid_lim_q;
  logic [15:0] ramp_int_q, report_int_q;

  // Control state
  logic [2:0]  state_q, state_d;
  logic        second_q, second_d;
  logic [2:0]  mode_q, mode_d;
  logic [7:0]  duty_q, duty_d;
  logic        en_q, en_d;
  logic [7:0]  pwm_up_q, pwm_up_d, pwm_dn_q, pwm_dn_d;
  logic [31:0] last_ramp_q, last_ramp_d, last_report_q, last_report_d;
  logic        out_valid_q, out_valid_d;
  logic        out_load;

  // Pass payload
  logic [31:0]       now_q;
  logic              upd_q, dnd_q, upl_q, dnl_q, upr_q, dnr_q;
  logic [ECHO_W-1:0] echo_q;

  // Output payload
  logic [7:0]     out_pwm_up_q, out_pwm_dn_q;
  logic           out_en_q;
  logic [2:0]     out_mode_q;
  logic [Q_W-1:0] out_height_q;

  meas_req_t meas_req;
  meas_rsp_t meas_rsp;

  logic             in_accept;
  logic [CNT_W-1:0] cnt_eff;
  logic [SUM_W-1:0] top_rhs, bot_rhs;
  logic             lt_top, gt_top, lt_bot, gt_bot;
  logic [31:0]      ramp_dt, report_dt;
  logic [8:0]       duty_sum;
  logic [7:0]       duty_ramp;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != S_IDLE;

  assign meas_req.start       = state_q == S_MSTART;
  assign meas_req.echo        = echo_q;
  assign meas_req.valid_limit = valid_lim_q;

  dmrc_avg u_avg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (meas_req),
    .rsp_o  (meas_rsp)
  );

  // Compare the exact average sum / count against limit * 256
  assign cnt_eff = (meas_rsp.count == '0) ? CNT_W'(1) : meas_rsp.count;
  assign top_rhs = {(SUM_W - 8)'(top_lim_q) * (SUM_W - 8)'(cnt_eff), 8'd0};
  assign bot_rhs = {(SUM_W - 8)'(bot_lim_q) * (SUM_W - 8)'(cnt_eff), 8'd0};
  assign lt_top  = meas_rsp.sum < top_rhs;
  assign gt_top  = meas_rsp.sum > top_rhs;
  assign lt_bot  = meas_rsp.sum < bot_rhs;
  assign gt_bot  = meas_rsp.sum > bot_rhs;

  assign ramp_dt   = now_q - last_ramp_q;
  assign report_dt = now_q - last_report_q;
  assign duty_sum  = {1'b0, duty_q} + {1'b0, speed_step_q};
  assign duty_ramp = (duty_sum > {1'b0, max_speed_q}) ? max_speed_q : duty_sum[7:0];

  always_comb begin
    state_d       = state_q;
    second_d      = second_q;
    mode_d        = mode_q;
    duty_d        = duty_q;
    en_d          = en_q;
    pwm_up_d      = pwm_up_q;
    pwm_dn_d      = pwm_dn_q;
    last_ramp_d   = last_ramp_q;
    last_report_d = last_report_q;
    out_load      = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EVENT;
        end
      end
      S_EVENT: begin
        second_d = 1'b0;
        state_d  = S_REPORT;
        if (upd_q) begin
          mode_d  = MODE_AUP;
          state_d = S_MSTART;
        end else if (dnd_q) begin
          mode_d  = MODE_ADOWN;
          state_d = S_MSTART;
        end else if (upl_q) begin
          if (mode_q != MODE_UP) begin
            en_d   = 1'b1;
            mode_d = MODE_UP;
            duty_d = min_speed_q;
          end
        end else if (dnl_q) begin
          if (mode_q != MODE_DOWN) begin
            en_d   = 1'b1;
            mode_d = MODE_DOWN;
            duty_d = min_speed_q;
          end
        end else if ((mode_q == MODE_UP || mode_q == MODE_DOWN) && (upr_q || dnr_q)) begin
          en_d     = 1'b0;
          pwm_up_d = '0;
          pwm_dn_d = '0;
          mode_d   = MODE_OFF;
        end
      end
      S_MSTART: begin
        state_d = S_MWAIT;
      end
      S_MWAIT: begin
        if (meas_rsp.done) begin
          state_d = S_MPOST;
        end
      end
      S_MPOST: begin
        if (!second_q) begin
          // Auto start: run only if inside the limits
          if ((mode_q == MODE_AUP && lt_top) || (mode_q == MODE_ADOWN && gt_bot)) begin
            en_d   = 1'b1;
            duty_d = min_speed_q;
          end
          state_d = S_REPORT;
        end else begin
          if ((mode_q == MODE_AUP && gt_top) || (mode_q == MODE_ADOWN && lt_bot)) begin
            en_d     = 1'b0;
            pwm_up_d = '0;
            pwm_dn_d = '0;
            mode_d   = MODE_OFF;
          end
          last_report_d = now_q;
          state_d       = S_RAMP;
        end
      end
      S_REPORT: begin
        if (report_dt >= {16'd0, report_int_q} &&
            (mode_q == MODE_AUP || mode_q == MODE_ADOWN)) begin
          second_d = 1'b1;
          state_d  = S_MSTART;
        end else begin
          state_d = S_RAMP;
        end
      end
      S_RAMP: begin
        if (ramp_dt >= {16'd0, ramp_int_q} && duty_q < max_speed_q &&
            duty_q >= min_speed_q && mode_q != MODE_OFF) begin
          duty_d      = duty_ramp;
          last_ramp_d = now_q;
        end
        if (mode_q == MODE_UP || mode_q == MODE_AUP) begin
          pwm_dn_d = '0;
          pwm_up_d = duty_d;
        end else if (mode_q == MODE_DOWN || mode_q == MODE_ADOWN) begin
          pwm_up_d = '0;
          pwm_dn_d = duty_d;
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        // Hold until the output register frees up
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      second_q      <= 1'b0;
      mode_q        <= MODE_OFF;
      duty_q        <= '0;
      en_q          <= 1'b0;
      pwm_up_q      <= '0;
      pwm_dn_q      <= '0;
      last_ramp_q   <= '0;
      last_report_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      second_q      <= second_d;
      mode_q        <= mode_d;
      duty_q        <= duty_d;
      en_q          <= en_d;
      pwm_up_q      <= pwm_up_d;
      pwm_dn_q      <= pwm_dn_d;
      last_ramp_q   <= last_ramp_d;
      last_report_q <= last_report_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q  <= 8'd100;
      max_speed_q  <= 8'd255;
      speed_step_q <= 8'd5;
      ramp_int_q   <= 16'd125;
      report_int_q <= 16'd100;
      top_lim_q    <= 8'd101;
      bot_lim_q    <= 8'd75;
      valid_lim_q  <= 8'd150;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_SPEED:  min_speed_q  <= cfg_data_i[7:0];
        CFG_MAX_SPEED:  max_speed_q  <= cfg_data_i[7:0];
        CFG_SPEED_STEP: speed_step_q <= cfg_data_i[7:0];
        CFG_RAMP_INT:   ramp_int_q   <= cfg_data_i;
        CFG_REPORT_INT: report_int_q <= cfg_data_i;
        CFG_TOP_LIM:    top_lim_q    <= cfg_data_i[7:0];
        CFG_BOT_LIM:    bot_lim_q    <= cfg_data_i[7:0];
        CFG_VALID_LIM:  valid_lim_q  <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the pass and the result
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      now_q  <= now_ms_i;
      upd_q  <= up_double_i;
      dnd_q  <= down_double_i;
      upl_q  <= up_long_i;
      dnl_q  <= down_long_i;
      upr_q  <= up_released_i;
      dnr_q  <= down_released_i;
      echo_q <= echo_us_i;
    end
    if (out_load) begin
      out_en_q     <= en_q;
      out_pwm_up_q <= pwm_up_q;
      out_pwm_dn_q <= pwm_dn_q;
      out_mode_q   <= mode_q;
      out_height_q <= meas_rsp.avg;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign motor_enable_o = out_en_q;
  assign pwm_up_o       = out_pwm_up_q;
  assign pwm_down_o     = out_pwm_dn_q;
  assign mode_o         = out_mode_q;
  assign height_q8_o    = out_height_q;

  a_out_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_OUT))
    else $error("result presented without a finished pass");

  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pwm_up_o == '0 || pwm_down_o == '0))
    else $error("both PWM directions driven");

  a_meas_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    meas_req.start |-> !meas_rsp.busy)
    else $error("measurement started while averaging unit busy");

endmodule

### verif/tb_desk_motor_ramp_controller_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the desk motor ramp controller: directed and random control passes.
module tb_desk_motor_ramp_controller_unit;
  import dmrc_pkg::*;

  // Button event bits of one control pass
  localparam logic [5:0] EV_UP_DOUBLE     = 6'b000001;
  localparam logic [5:0] EV_DOWN_DOUBLE   = 6'b000010;
  localparam logic [5:0] EV_UP_LONG       = 6'b000100;
  localparam logic [5:0] EV_DOWN_LONG     = 6'b001000;
  localparam logic [5:0] EV_UP_RELEASED   = 6'b010000;
  localparam logic [5:0] EV_DOWN_RELEASED = 6'b100000;
  localparam logic [5:0] EV_NONE          = 6'b000000;

  typedef struct {
    logic [31:0]       now_ms;
    logic [5:0]        events;
    logic [ECHO_W-1:0] echo_us;
    int unsigned       gap;
  } pass_t;

  typedef struct {
    logic           motor_enable;
    logic [7:0]     pwm_up;
    logic [7:0]     pwm_down;
    logic [2:0]     mode;
    logic [Q_W-1:0] height_q8;
  } drive_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [31:0]          now_ms_i = '0;
  logic                 up_double_i = 1'b0;
  logic                 down_double_i = 1'b0;
  logic                 up_long_i = 1'b0;
  logic                 down_long_i = 1'b0;
  logic                 up_released_i = 1'b0;
  logic                 down_released_i = 1'b0;
  logic [ECHO_W-1:0]    echo_us_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 motor_enable_o;
  logic [7:0]           pwm_up_o;
  logic [7:0]           pwm_down_o;
  logic [2:0]           mode_o;
  logic [Q_W-1:0]       height_q8_o;

  desk_motor_ramp_controller_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .now_ms_i        (now_ms_i),
    .up_double_i     (up_double_i),
    .down_double_i   (down_double_i),
    .up_long_i       (up_long_i),
    .down_long_i     (down_long_i),
    .up_released_i   (up_released_i),
    .down_released_i (down_released_i),
    .echo_us_i       (echo_us_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .motor_enable_o  (motor_enable_o),
    .pwm_up_o        (pwm_up_o),
    .pwm_down_o      (pwm_down_o),
    .mode_o          (mode_o),
    .height_q8_o     (height_q8_o)
  );

  // Register copy used for prediction
  logic [7:0]  cfg_min_speed  = 8'd100;
  logic [7:0]  cfg_max_speed  = 8'd255;
  logic [7:0]  cfg_speed_step = 8'd5;
  logic [15:0] cfg_ramp_int   = 16'd125;
  logic [15:0] cfg_report_int = 16'd100;
  logic [7:0]  cfg_top_lim    = 8'd101;
  logic [7:0]  cfg_bot_lim    = 8'd75;
  logic [7:0]  cfg_valid_lim  = 8'd150;

  // Predicted controller state
  logic [2:0]       run_mode = MODE_OFF;
  logic [7:0]       duty = '0;
  logic             motor_on = 1'b0;
  logic [7:0]       pwm_up_q = '0;
  logic [7:0]       pwm_down_q = '0;
  logic [31:0]      last_ramp_ms = '0;
  logic [31:0]      last_report_ms = '0;
  logic [Q_W-1:0]   ring_q8 [AVG_WINDOW];
  logic [PTR_W-1:0] ring_ptr = '0;
  logic [CNT_W-1:0] ring_cnt = '0;
  logic [SUM_W-1:0] ring_sum = '0;
  logic [Q_W-1:0]   avg_q8 = '0;

  pass_t       pass_q [$];
  drive_t      expected_q [$];
  pass_t       tx_pass;
  bit          tx_have_item = 1'b0;
  int unsigned tx_gap_left = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  bit          rx_hold_req = 1'b0;
  int unsigned rx_wait_left = 0;
  int unsigned rx_hold_left = 0;
  logic [31:0] sim_ms = '0;
  int          mismatches = 0;
  int          passes_accepted = 0;
  int          results_checked = 0;
  int          settings_applied = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #1_000_000;
    $display("%0t: timeout, %0d results still pending", $time, expected_q.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void take_reading(logic [ECHO_W-1:0] echo);
    longint unsigned e;
    longint unsigned lim;
    logic [Q_W-1:0]  q;
    int unsigned     slot;
    e = echo;
    lim = cfg_valid_lim;
    if (e * 17 < lim * 1000) begin
      q = Q_W'((e * 4352) / 1000);
      slot = ring_ptr;
      if (ring_cnt >= AVG_WINDOW) ring_sum = ring_sum - ring_q8[slot];
      else ring_cnt = ring_cnt + 1'b1;
      ring_q8[slot] = q;
      ring_sum = ring_sum + q;
      ring_ptr = PTR_W'((slot + 1) % AVG_WINDOW);
    end
    avg_q8 = (ring_cnt != 0) ? Q_W'(ring_sum / ring_cnt) : '0;
  endfunction

  // Sign of (sum / count - limit * 256), exact; an empty ring counts as zero
  function automatic int height_vs_limit(logic [7:0] limit_cm);
    longint unsigned lhs, rhs, n;
    lhs = (ring_cnt != 0) ? ring_sum : 0;
    n = (ring_cnt != 0) ? ring_cnt : 1;
    rhs = limit_cm;
    rhs = rhs * 256 * n;
    return (lhs < rhs) ? -1 : ((lhs > rhs) ? 1 : 0);
  endfunction

  function automatic void halt_motor();
    motor_on = 1'b0;
    pwm_up_q = '0;
    pwm_down_q = '0;
    run_mode = MODE_OFF;
  endfunction

  function automatic drive_t predict_control_pass(pass_t p);
    drive_t      d;
    logic [31:0] since;
    int unsigned raised;
    if (p.events & EV_UP_DOUBLE) begin
      run_mode = MODE_AUP;
      take_reading(p.echo_us);
      if (height_vs_limit(cfg_top_lim) < 0) begin
        motor_on = 1'b1;
        duty = cfg_min_speed;
      end
    end else if (p.events & EV_DOWN_DOUBLE) begin
      run_mode = MODE_ADOWN;
      take_reading(p.echo_us);
      if (height_vs_limit(cfg_bot_lim) > 0) begin
        motor_on = 1'b1;
        duty = cfg_min_speed;
      end
    end else if (p.events & EV_UP_LONG) begin
      if (run_mode != MODE_UP) begin
        motor_on = 1'b1;
        run_mode = MODE_UP;
        duty = cfg_min_speed;
      end
    end else if (p.events & EV_DOWN_LONG) begin
      if (run_mode != MODE_DOWN) begin
        motor_on = 1'b1;
        run_mode = MODE_DOWN;
        duty = cfg_min_speed;
      end
    end else if ((run_mode == MODE_UP || run_mode == MODE_DOWN) &&
                 (p.events & (EV_UP_RELEASED | EV_DOWN_RELEASED))) begin
      halt_motor();
    end

    since = p.now_ms - last_report_ms;
    if (since >= cfg_report_int && (run_mode == MODE_AUP || run_mode == MODE_ADOWN)) begin
      // reuse the same echo for the periodic check
      take_reading(p.echo_us);
      if (run_mode == MODE_AUP) begin
        if (height_vs_limit(cfg_top_lim) > 0) halt_motor();
      end else begin
        if (height_vs_limit(cfg_bot_lim) < 0) halt_motor();
      end
      last_report_ms = p.now_ms;
    end

    since = p.now_ms - last_ramp_ms;
    if (since >= cfg_ramp_int && duty < cfg_max_speed && duty >= cfg_min_speed &&
        run_mode != MODE_OFF) begin
      raised = duty + cfg_speed_step;
      duty = (raised > cfg_max_speed) ? cfg_max_speed : 8'(raised);
      last_ramp_ms = p.now_ms;
    end

    if (run_mode == MODE_UP || run_mode == MODE_AUP) begin
      pwm_down_q = '0;
      pwm_up_q = duty;
    end else if (run_mode == MODE_DOWN || run_mode == MODE_ADOWN) begin
      pwm_up_q = '0;
      pwm_down_q = duty;
    end

    d.motor_enable = motor_on;
    d.pwm_up = pwm_up_q;
    d.pwm_down = pwm_down_q;
    d.mode = run_mode;
    d.height_q8 = avg_q8;
    return d;
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      tx_have_item = 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(predict_control_pass(tx_pass));
        passes_accepted++;
        tx_have_item = 1'b0;
      end
      if (!tx_have_item && pass_q.size() != 0) begin
        tx_pass = pass_q.pop_front();
        tx_have_item = 1'b1;
        tx_gap_left = tx_pass.gap;
      end
      if (tx_have_item && tx_gap_left == 0) begin
        in_valid_i      <= 1'b1;
        now_ms_i        <= tx_pass.now_ms;
        up_double_i     <= (tx_pass.events & EV_UP_DOUBLE) != 0;
        down_double_i   <= (tx_pass.events & EV_DOWN_DOUBLE) != 0;
        up_long_i       <= (tx_pass.events & EV_UP_LONG) != 0;
        down_long_i     <= (tx_pass.events & EV_DOWN_LONG) != 0;
        up_released_i   <= (tx_pass.events & EV_UP_RELEASED) != 0;
        down_released_i <= (tx_pass.events & EV_DOWN_RELEASED) != 0;
        echo_us_i       <= tx_pass.echo_us;
      end else begin
        in_valid_i <= 1'b0;
        if (tx_have_item) tx_gap_left--;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i) begin : rx_side
    drive_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      rx_wait_left = 0;
      rx_hold_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_checked++;
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected transaction, expected none, got mode %0d height %0d",
                   $time, mode_o, height_q8_o);
        end else begin
          want = expected_q.pop_front();
          check_field("motor_enable", want.motor_enable, motor_enable_o);
          check_field("pwm_up", want.pwm_up, pwm_up_o);
          check_field("pwm_down", want.pwm_down, pwm_down_o);
          check_field("mode", want.mode, mode_o);
          check_field("height_q8", want.height_q8, height_q8_o);
        end
        rx_wait_left = rx_quiet ? 0 : $urandom_range(0, 7);
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rx_hold_left = 300;
      end
      if (rx_hold_left != 0) begin
        rx_hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_wait_left != 0) begin
        rx_wait_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic add_pass(input logic [31:0] t, input logic [5:0] ev,
                          input logic [ECHO_W-1:0] echo);
    pass_t p;
    p.now_ms = t;
    p.events = ev;
    p.echo_us = echo;
    p.gap = tx_quiet ? 0 : $urandom_range(0, 7);
    pass_q.push_back(p);
  endtask

  function automatic logic [ECHO_W-1:0] echo_for_cm(int cm);
    return ECHO_W'(cm * 1000 / 17 + $urandom_range(0, 40));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_MIN_SPEED:  cfg_min_speed  = data[7:0];
      CFG_MAX_SPEED:  cfg_max_speed  = data[7:0];
      CFG_SPEED_STEP: cfg_speed_step = data[7:0];
      CFG_RAMP_INT:   cfg_ramp_int   = data;
      CFG_REPORT_INT: cfg_report_int = data;
      CFG_TOP_LIM:    cfg_top_lim    = data[7:0];
      CFG_BOT_LIM:    cfg_bot_lim    = data[7:0];
      CFG_VALID_LIM:  cfg_valid_lim  = data[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] min_spd, input logic [15:0] max_spd,
                                input logic [15:0] step, input logic [15:0] ramp,
                                input logic [15:0] report, input logic [15:0] top,
                                input logic [15:0] bot, input logic [15:0] valid_lim);
    write_reg(CFG_MIN_SPEED, min_spd);
    write_reg(CFG_MAX_SPEED, max_spd);
    write_reg(CFG_SPEED_STEP, step);
    write_reg(CFG_RAMP_INT, ramp);
    write_reg(CFG_REPORT_INT, report);
    write_reg(CFG_TOP_LIM, top);
    write_reg(CFG_BOT_LIM, bot);
    write_reg(CFG_VALID_LIM, valid_lim);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_applied++;
  endtask

  // Hold the sender until every result is back, then let the block settle
  task automatic drain();
    while (pass_q.size() != 0 || tx_have_item || expected_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic gen_random_passes(input int count);
    int               left, kind, len, cm, step_dir, j;
    logic [5:0]       ev, start_ev, stop_ev;
    logic [ECHO_W-1:0] echo;
    left = count;
    cm = $urandom_range(40, 160);
    while (left > 0) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(2, 12);
      stop_ev = EV_NONE;
      case (kind)
        0, 1, 2: begin
          start_ev = EV_UP_DOUBLE;
          step_dir = 1;
        end
        3, 4, 5: begin
          start_ev = EV_DOWN_DOUBLE;
          step_dir = -1;
        end
        6: begin
          start_ev = EV_UP_LONG;
          stop_ev = $urandom_range(0, 1) ? EV_UP_RELEASED : EV_DOWN_RELEASED;
          step_dir = 1;
        end
        7: begin
          start_ev = EV_DOWN_LONG;
          stop_ev = $urandom_range(0, 1) ? EV_DOWN_RELEASED : EV_UP_RELEASED;
          step_dir = -1;
        end
        default: begin
          start_ev = EV_NONE;
          step_dir = 0;
        end
      endcase
      for (j = 0; j < len && left > 0; j++) begin
        if ($urandom_range(0, 29) == 0) sim_ms = $urandom;
        else sim_ms += $urandom_range(0, 160);
        if (kind >= 8) begin
          ev = 6'($urandom) & 6'($urandom);
          echo = ECHO_W'($urandom);
        end else begin
          if (j == 0) ev = start_ev;
          else if (j == len - 1) ev = stop_ev;
          else ev = EV_NONE;
          // long click keeps firing while the button is held
          if (j != 0 && j != len - 1 && stop_ev != EV_NONE && $urandom_range(0, 2) == 0)
            ev = start_ev;
          if ($urandom_range(0, 11) == 0) ev |= 6'b1 << $urandom_range(0, 5);
          if ($urandom_range(0, 9) != 0) echo = echo_for_cm(cm);
          else if ($urandom_range(0, 1) != 0) echo = '0;
          else echo = ECHO_W'($urandom);
        end
        cm += step_dir * int'($urandom_range(0, 4));
        if (cm < 0) cm = 0;
        if (cm > 250) cm = 250;
        add_pass(sim_ms, ev, echo);
        left--;
      end
    end
  endtask

  initial begin
    int r;
    logic [15:0] lo_spd;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed passes on the reset settings
    add_pass(32'd0, EV_NONE, 20'd0);
    add_pass(32'd10, EV_UP_LONG, 20'd0);
    add_pass(32'd200, EV_UP_LONG, 20'd5000);
    add_pass(32'd210, EV_UP_RELEASED, 20'd5000);
    add_pass(32'd300, EV_DOWN_LONG, 20'd5000);
    add_pass(32'd330, EV_DOWN_LONG, 20'd5000);
    add_pass(32'd340, EV_UP_RELEASED | EV_DOWN_RELEASED, 20'd5000);
    add_pass(32'd400, EV_UP_DOUBLE, 20'd5000);
    add_pass(32'd520, EV_NONE, 20'd5600);
    add_pass(32'd640, EV_NONE, 20'd8823);
    add_pass(32'd760, EV_NONE, 20'd8824);
    add_pass(32'd880, EV_NONE, 20'd6500);
    add_pass(32'd900, EV_DOWN_DOUBLE, 20'hFFFFF);
    add_pass(32'd1000, EV_NONE, 20'd0);
    add_pass(32'd1100, EV_UP_RELEASED, 20'd4000);
    add_pass(32'd1200, 6'b111111, 20'd3000);
    add_pass(32'd1210, EV_UP_LONG | EV_DOWN_LONG, 20'd3000);
    add_pass(32'd1300, EV_DOWN_LONG | EV_UP_RELEASED, 20'd3000);
    add_pass(32'd1310, EV_DOWN_RELEASED, 20'd3000);
    add_pass(32'hFFFF_FF00, EV_UP_LONG, 20'd4400);
    add_pass(32'h0000_0040, EV_UP_LONG, 20'd4400);
    add_pass(32'h8000_0000, EV_DOWN_RELEASED, 20'd0);
    sim_ms = 32'd5000;
    gen_random_passes(80);
    drain();

    // One extreme: fastest ramp and reports, widest limits
    apply_settings(16'd0, 16'd255, 16'd1, 16'd0, 16'd0, 16'd255, 16'd0, 16'd255);
    tx_quiet = 1'b1;
    rx_hold_req = 1'b1;
    gen_random_passes(30);
    tx_quiet = 1'b0;
    gen_random_passes(40);
    drain();

    // Other extreme: no ramping, no valid reading, crossed limits
    apply_settings(16'd255, 16'd0, 16'd255, 16'hFFFF, 16'hFFFF, 16'd0, 16'd255, 16'd0);
    rx_quiet = 1'b1;
    gen_random_passes(60);
    drain();
    rx_quiet = 1'b0;

    // Random settings, with junk in the unused upper byte of the 8-bit registers
    for (r = 0; r < 3; r++) begin
      lo_spd = $urandom_range(0, 200);
      apply_settings({8'($urandom), lo_spd[7:0]},
                     {8'($urandom), 8'($urandom_range(lo_spd, 255))},
                     {8'($urandom), 8'($urandom_range(1, 255))},
                     16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)),
                     {8'($urandom), 8'($urandom_range(60, 140))},
                     {8'($urandom), 8'($urandom_range(40, 110))},
                     {8'($urandom), 8'($urandom_range(100, 255))});
      gen_random_passes(45);
      drain();
    end

    // Back to the power-on values
    apply_settings(16'd100, 16'd255, 16'd5, 16'd125, 16'd100, 16'd101, 16'd75, 16'd150);
    gen_random_passes(50);
    drain();

    $display("Checked %0d results from %0d control passes over %0d register settings.",
             results_checked, passes_accepted, settings_applied + 1);
    $display("Passes covered manual and auto motion, limit stops, noise and time wrap.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
